/* rtl/rar_pkg.sv */
`default_nettype none
package rar_pkg;

  // fixed field formats of the rotate unit
  localparam int COORD_WIDTH = 32;
  localparam int ANGLE_BITS  = 16;
  localparam int AXIS_WIDTH  = 32;

  // q30 constants
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // taylor denominators per poly cell, zero means the sine term passes through
  localparam int SIN_DEN [8] = '{210, 156, 110, 72, 42, 20, 6, 0};
  localparam int COS_DEN [8] = '{240, 182, 132, 90, 56, 30, 12, 2};

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;
    logic signed [AXIS_WIDTH-1:0]  axis_x;
    logic signed [AXIS_WIDTH-1:0]  axis_y;
    logic signed [AXIS_WIDTH-1:0]  axis_z;
    logic [ANGLE_BITS-1:0]         turn_angle;
  } req_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;
  } res_t;

  // payload that rides along the sine/cosine chain
  typedef struct packed {
    logic [30:0]                   x;
    logic [1:0]                    quad;
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic signed [COORD_WIDTH-1:0] vz;
    logic signed [AXIS_WIDTH-1:0]  ax;
    logic signed [AXIS_WIDTH-1:0]  ay;
    logic signed [AXIS_WIDTH-1:0]  az;
  } side_t;

endpackage
`default_nettype wire

/* rtl/rar_poly_cell.sv */
`default_nettype none
// one horner step of the sine and cosine polynomials: t = 1 - x2*t/d, two stages
module rar_poly_cell #(
  parameter int DS = 0,
  parameter int DC = 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [31:0]         x2_in,
  input  wire logic signed [31:0]  ts_in,
  input  wire logic signed [31:0]  tc_in,
  input  wire rar_pkg::side_t      side_in,
  output logic                     out_valid,
  output logic [31:0]              x2_out,
  output logic signed [31:0]       ts_out,
  output logic signed [31:0]       tc_out,
  output rar_pkg::side_t           side_out
);

  localparam int DSE = (DS == 0) ? 1 : DS;
  localparam int LS  = $clog2(DSE);
  localparam int LC  = $clog2(DC);
  // reciprocal multipliers, exact floor division for 32-bit dividends
  localparam logic [63:0] MS64 = ((64'd1 << (32 + LS)) + 64'(DSE) - 64'd1) / 64'(DSE);
  localparam logic [63:0] MC64 = ((64'd1 << (32 + LC)) + 64'(DC) - 64'd1) / 64'(DC);

  logic                a_valid;
  logic [31:0]         a_x2;
  logic signed [31:0]  a_ts;
  logic [61:0]         a_ps;
  logic [61:0]         a_pc;
  rar_pkg::side_t      a_side;

  logic [64:0]         ms_prod;
  logic [64:0]         mc_prod;
  logic [32:0]         qs;
  logic [32:0]         qc;
  logic signed [31:0]  ts_next;
  logic signed [31:0]  tc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_x2   <= x2_in;
    a_ts   <= ts_in;
    a_ps   <= 62'(x2_in) * 62'(ts_in[30:0]);
    a_pc   <= 62'(x2_in) * 62'(tc_in[30:0]);
    a_side <= side_in;
  end

  always_comb begin
    ms_prod = 65'(a_ps[61:30]) * 65'(MS64[32:0]);
    mc_prod = 65'(a_pc[61:30]) * 65'(MC64[32:0]);
    qs      = 33'(ms_prod >> (32 + LS));
    qc      = 33'(mc_prod >> (32 + LC));
    ts_next = (DS == 0) ? a_ts : 32'(33'(rar_pkg::ONE_Q30) - qs);
    tc_next = 32'(33'(rar_pkg::ONE_Q30) - qc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
    x2_out   <= a_x2;
    ts_out   <= ts_next;
    tc_out   <= tc_next;
    side_out <= a_side;
  end

endmodule
`default_nettype wire

/* rtl/vector3_axis_angle_rotate_unit.sv */
`default_nettype none
// rodrigues axis-angle rotation, fully pipelined
// a request runs through capture, radians, x squared, the 8-cell poly chain and the matrix stages
// throughput: one request per cycle, busy never asserts; every stage takes a new request each cycle
// results show for exactly one cycle with done, the receiver cannot stall
// reset (rst, synchronous) clears every stage valid, requests in flight are dropped
module vector3_axis_angle_rotate_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire rar_pkg::req_t  req,
  output logic                done,
  output rar_pkg::res_t       result
);

  localparam int CW    = rar_pkg::COORD_WIDTH;
  localparam int AB    = rar_pkg::ANGLE_BITS;
  localparam int SPLIT = CW / 2;
  localparam int PLW   = SPLIT + 36;
  localparam int PHW   = CW - SPLIT + 35;
  localparam int TW    = CW + 40;
  localparam int LAT   = 25;
  localparam int NCELL = 8;

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;

  localparam logic signed [31:0] ONE_S  = 32'sh4000_0000;
  localparam logic signed [31:0] MONE_S = -32'sh4000_0000;
  localparam logic signed [TW-1:0] RMAX = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [TW-1:0] RMIN = ~RMAX;

  function automatic logic signed [65:0] rnd30(input logic signed [65:0] p);
    return (p + 66'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp_axis(input logic signed [31:0] a);
    if (a > ONE_S) return ONE_S;
    if (a < MONE_S) return MONE_S;
    return a;
  endfunction

  // every request is taken at once
  assign busy = 1'b0;

  // ---------------------------------------------------------------- capture
  logic                s0_valid;
  rar_pkg::side_t      s0_side;
  logic [AB-3:0]       s0_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_side.x    <= '0;
    s0_side.quad <= req.turn_angle[AB-1:AB-2];
    s0_side.vx   <= req.vec_x;
    s0_side.vy   <= req.vec_y;
    s0_side.vz   <= req.vec_z;
    s0_side.ax   <= clamp_axis(req.axis_x);
    s0_side.ay   <= clamp_axis(req.axis_y);
    s0_side.az   <= clamp_axis(req.axis_z);
    s0_q         <= req.turn_angle[AB-3:0];
  end

  // ---------------------------------------------------------------- angle to radians
  logic                s1_valid;
  rar_pkg::side_t      s1_side;
  rar_pkg::side_t      s1_side_next;

  always_comb begin
    s1_side_next   = s0_side;
    // reduced angle is below pi/2 so 31 bits hold it
    s1_side_next.x = 31'((64'(s0_q) * 64'(rar_pkg::PI_Q30)) >> (AB - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    s1_side <= s1_side_next;
  end

  // ---------------------------------------------------------------- x squared
  logic                s2_valid;
  rar_pkg::side_t      s2_side;
  logic [31:0]         s2_x2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_side <= s1_side;
    s2_x2   <= 32'((64'(s1_side.x) * 64'(s1_side.x) + 64'd536870912) >> 30);
  end

  // ---------------------------------------------------------------- horner chain
  logic                cv   [NCELL+1];
  logic [31:0]         cx2  [NCELL+1];
  logic signed [31:0]  cts  [NCELL+1];
  logic signed [31:0]  ctc  [NCELL+1];
  rar_pkg::side_t      cside[NCELL+1];

  assign cv[0]    = s2_valid;
  assign cx2[0]   = s2_x2;
  assign cts[0]   = ONE_S;
  assign ctc[0]   = ONE_S;
  assign cside[0] = s2_side;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    rar_poly_cell #(
      .DS(rar_pkg::SIN_DEN[k]),
      .DC(rar_pkg::COS_DEN[k])
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[k]),
      .x2_in    (cx2[k]),
      .ts_in    (cts[k]),
      .tc_in    (ctc[k]),
      .side_in  (cside[k]),
      .out_valid(cv[k+1]),
      .x2_out   (cx2[k+1]),
      .ts_out   (cts[k+1]),
      .tc_out   (ctc[k+1]),
      .side_out (cside[k+1])
    );
  end

  // ---------------------------------------------------------------- sine, cosine, quadrant
  logic [61:0]         sx_prod;
  logic [31:0]         sv_raw;
  logic signed [31:0]  sv;
  logic signed [31:0]  cvv;
  logic signed [31:0]  sin_n;
  logic signed [31:0]  cos_n;

  always_comb begin
    sx_prod = 62'(cside[NCELL].x) * 62'(cts[NCELL][30:0]);
    sv_raw  = 32'((sx_prod + 62'd536870912) >> 30);
    sv      = (sv_raw > 32'(ONE_S)) ? ONE_S : $signed(sv_raw);
    if (ctc[NCELL] < 0) begin
      cvv = '0;
    end else if (ctc[NCELL] > ONE_S) begin
      cvv = ONE_S;
    end else begin
      cvv = ctc[NCELL];
    end
    case (cside[NCELL].quad)
      QUAD_FIRST: begin
        sin_n = sv;
        cos_n = cvv;
      end
      QUAD_SECOND: begin
        sin_n = cvv;
        cos_n = -sv;
      end
      QUAD_THIRD: begin
        sin_n = -sv;
        cos_n = -cvv;
      end
      default: begin
        sin_n = -cvv;
        cos_n = sv;
      end
    endcase
  end

  logic                s3_valid;
  rar_pkg::side_t      s3_side;
  logic signed [31:0]  s3_s;
  logic signed [31:0]  s3_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= cv[NCELL];
    end
    s3_side <= cside[NCELL];
    s3_s    <= sin_n;
    s3_c    <= cos_n;
  end

  // ---------------------------------------------------------------- axis products, skew terms
  // aa order: xx, yy, zz, xy, xz, yz
  logic                s4_valid;
  logic signed [31:0]  s4_aa [6];
  logic signed [31:0]  s4_sk [3];
  logic signed [32:0]  s4_va;
  logic signed [31:0]  s4_c;
  logic signed [CW-1:0] s4_v [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_aa[0] <= 32'(rnd30(66'(s3_side.ax) * 66'(s3_side.ax)));
    s4_aa[1] <= 32'(rnd30(66'(s3_side.ay) * 66'(s3_side.ay)));
    s4_aa[2] <= 32'(rnd30(66'(s3_side.az) * 66'(s3_side.az)));
    s4_aa[3] <= 32'(rnd30(66'(s3_side.ax) * 66'(s3_side.ay)));
    s4_aa[4] <= 32'(rnd30(66'(s3_side.ax) * 66'(s3_side.az)));
    s4_aa[5] <= 32'(rnd30(66'(s3_side.ay) * 66'(s3_side.az)));
    s4_sk[0] <= 32'(rnd30(66'(s3_side.ax) * 66'(s3_s)));
    s4_sk[1] <= 32'(rnd30(66'(s3_side.ay) * 66'(s3_s)));
    s4_sk[2] <= 32'(rnd30(66'(s3_side.az) * 66'(s3_s)));
    s4_va    <= 33'(ONE_S) - 33'(s3_c);
    s4_c     <= s3_c;
    s4_v[0]  <= s3_side.vx;
    s4_v[1]  <= s3_side.vy;
    s4_v[2]  <= s3_side.vz;
  end

  // ---------------------------------------------------------------- rotation matrix
  logic signed [34:0]  p_aa [6];
  logic signed [34:0]  m_n  [3][3];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      p_aa[i] = 35'(rnd30(66'(s4_aa[i]) * 66'(s4_va)));
    end
    m_n[0][0] = p_aa[0] + 35'(s4_c);
    m_n[1][1] = p_aa[1] + 35'(s4_c);
    m_n[2][2] = p_aa[2] + 35'(s4_c);
    m_n[0][1] = p_aa[3] - 35'(s4_sk[2]);
    m_n[1][0] = p_aa[3] + 35'(s4_sk[2]);
    m_n[0][2] = p_aa[4] + 35'(s4_sk[1]);
    m_n[2][0] = p_aa[4] - 35'(s4_sk[1]);
    m_n[1][2] = p_aa[5] - 35'(s4_sk[0]);
    m_n[2][1] = p_aa[5] + 35'(s4_sk[0]);
  end

  logic                 s5_valid;
  logic signed [34:0]   s5_m [3][3];
  logic signed [CW-1:0] s5_v [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_m <= m_n;
    s5_v <= s4_v;
  end

  // ---------------------------------------------------------------- split partial products
  // each vector component is cut in a low unsigned and a high signed half
  logic                  s6_valid;
  logic signed [PLW-1:0] s6_plo [3][3];
  logic signed [PHW-1:0] s6_phi [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s6_plo[i][j] <= PLW'($signed({1'b0, s5_v[j][SPLIT-1:0]})) * PLW'(s5_m[i][j]);
        s6_phi[i][j] <= PHW'($signed(s5_v[j][CW-1:SPLIT])) * PHW'(s5_m[i][j]);
      end
    end
  end

  // ---------------------------------------------------------------- row sums
  logic                 s7_valid;
  logic signed [TW-1:0] s7_lo [3];
  logic signed [TW-1:0] s7_hi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    for (int i = 0; i < 3; i++) begin
      // half lsb of q30 folded into the low sum
      s7_lo[i] <= TW'(s6_plo[i][0]) + TW'(s6_plo[i][1]) + TW'(s6_plo[i][2])
                  + (TW'(1) <<< 29);
      s7_hi[i] <= TW'(s6_phi[i][0]) + TW'(s6_phi[i][1]) + TW'(s6_phi[i][2]);
    end
  end

  // ---------------------------------------------------------------- combine, round, saturate
  logic signed [TW-1:0] tot  [3];
  logic signed [TW-1:0] rq   [3];
  logic signed [CW-1:0] sat  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (s7_hi[i] <<< SPLIT) + s7_lo[i];
      rq[i]  = tot[i] >>> 30;
      if (rq[i] > RMAX) begin
        sat[i] = CW'(RMAX);
      end else if (rq[i] < RMIN) begin
        sat[i] = CW'(RMIN);
      end else begin
        sat[i] = CW'(rq[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s7_valid;
    end
    result.rot_x <= sat[0];
    result.rot_y <= sat[1];
    result.rot_z <= sat[2];
  end

  // ---------------------------------------------------------------- checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request did not complete after pipeline latency");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s7_valid))
    else $error("done without a request in the last stage");

  a_sin_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_s <= ONE_S && s3_s >= MONE_S && s3_c <= ONE_S && s3_c >= MONE_S))
    else $error("sine or cosine outside unit range");

  a_va_pos: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> !s4_va[32])
    else $error("one minus cosine went negative");

endmodule
`default_nettype wire
